// File: rtl/core/tzda_pkg.sv
`timescale 1ns / 1ps

package tzda_pkg;

    // field widths of one clock reading
    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 7;
    localparam int OFFS_W  = 6;

    // packed word layout, lowest field first, padded to whole bytes
    localparam int SEC_LSB   = 0;
    localparam int MIN_LSB   = SEC_LSB + SEC_W;
    localparam int HOUR_LSB  = MIN_LSB + MIN_W;
    localparam int DAY_LSB   = HOUR_LSB + HOUR_W;
    localparam int MONTH_LSB = DAY_LSB + DAY_W;
    localparam int YEAR_LSB  = MONTH_LSB + MONTH_W;
    localparam int USED_W    = YEAR_LSB + YEAR_W;
    localparam int TDATA_W   = ((USED_W + 7) / 8) * 8;

    // config port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_HOUR_OFFSET = 1'b0;   // register index, paddr[2]

    localparam logic [HOUR_W-1:0]  HOURS_PER_DAY = 5'd24;
    localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;
    localparam logic [YEAR_W-1:0]  YEAR_LAST     = 7'd99;
    localparam logic [YEAR_W-1:0]  YEAR_2100     = 7'd100;
    localparam logic [DAY_W-1:0]   FEB_LEAP_LEN  = 5'd29;

    // month lengths indexed by month code; unused codes count as 31 days
    localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
        5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
    };

    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_FWD,
        STEP_BACK
    } t_step;

    // day steps produced by the hour wrap, applied in order
    typedef struct packed {
        t_step step1;
        t_step step2;
    } t_wrap;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    // length of a month in 2000+year; 2000 is leap, 2100 is not
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic [YEAR_W-1:0] y);
        logic leap;
        leap = (y[1:0] == 2'b00) && (y != YEAR_2100);
        if ((m == MONTH_FEB) && leap) begin
            return FEB_LEAP_LEN;
        end
        return MONTH_LEN[m];
    endfunction

endpackage

// File: rtl/core/tzda_cfg_regs.sv
`timescale 1ns / 1ps

module tzda_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tzda_pkg::PADDR_W-1:0]   paddr,
    input  logic [tzda_pkg::PDATA_W-1:0]   pwdata,
    output logic [tzda_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output logic signed [tzda_pkg::OFFS_W-1:0] o_hour_offset
);
    import tzda_pkg::*;

    logic                     wr_en;
    logic signed [OFFS_W-1:0] r_hour_offset;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_HOUR_OFFSET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour_offset <= '0;
        end else if (wr_en) begin
            r_hour_offset <= pwdata[OFFS_W-1:0];
        end
    end

    // read back sign-extended
    always_comb begin
        if (paddr[2] == REG_HOUR_OFFSET) begin
            prdata = {{(PDATA_W-OFFS_W){r_hour_offset[OFFS_W-1]}}, r_hour_offset};
        end else begin
            prdata = '0;
        end
    end

    assign o_hour_offset = r_hour_offset;

endmodule

// File: rtl/core/tzda_hour_wrap.sv
`timescale 1ns / 1ps

module tzda_hour_wrap (
    input  logic [tzda_pkg::HOUR_W-1:0]        i_hours,
    input  logic signed [tzda_pkg::OFFS_W-1:0] i_offset,
    output logic [tzda_pkg::HOUR_W-1:0]        o_hours,
    output tzda_pkg::t_wrap                    o_wrap
);
    import tzda_pkg::*;

    localparam int SUM_W = HOUR_W + 2;

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] one_day;
    logic signed [SUM_W-1:0] two_days;
    logic signed [SUM_W-1:0] adj;

    assign one_day  = signed'({2'b00, HOURS_PER_DAY});
    assign two_days = one_day <<< 1;
    assign sum = signed'({2'b00, i_hours})
               + signed'({{(SUM_W-OFFS_W){i_offset[OFFS_W-1]}}, i_offset});

    // sum spans -32..62, so at most two whole days either way
    always_comb begin
        priority if (sum >= two_days) begin
            adj    = sum - two_days;
            o_wrap = '{step1: STEP_FWD, step2: STEP_FWD};
        end else if (sum >= one_day) begin
            adj    = sum - one_day;
            o_wrap = '{step1: STEP_FWD, step2: STEP_NONE};
        end else if (sum >= 0) begin
            adj    = sum;
            o_wrap = '{step1: STEP_NONE, step2: STEP_NONE};
        end else if (sum >= -one_day) begin
            adj    = sum + one_day;
            o_wrap = '{step1: STEP_BACK, step2: STEP_NONE};
        end else begin
            adj    = sum + two_days;
            o_wrap = '{step1: STEP_BACK, step2: STEP_BACK};
        end
    end

    assign o_hours = adj[HOUR_W-1:0];

endmodule

// File: rtl/core/tzda_cal_step.sv
`timescale 1ns / 1ps

module tzda_cal_step (
    input  tzda_pkg::t_date i_date,
    input  tzda_pkg::t_step i_step,
    output tzda_pkg::t_date o_date
);
    import tzda_pkg::*;

    logic [DAY_W:0]     day_inc;
    logic [DAY_W-1:0]   len_cur;
    logic [DAY_W-1:0]   len_prev;
    logic [MONTH_W-1:0] month_prev;
    logic [YEAR_W-1:0]  year_prev;
    logic               wrap_back;

    assign day_inc = {1'b0, i_date.day} + 1'b1;
    assign len_cur = month_days(i_date.month, i_date.year);

    // previous month; January and month 0 fall back to December of last year
    assign wrap_back  = (i_date.month <= MONTH_JAN);
    assign month_prev = wrap_back ? MONTH_DEC : i_date.month - 1'b1;
    assign year_prev  = !wrap_back ? i_date.year :
                        ((i_date.year == '0) || (i_date.year > YEAR_LAST)) ? YEAR_LAST :
                        i_date.year - 1'b1;
    assign len_prev   = month_days(month_prev, year_prev);

    always_comb begin
        o_date = i_date;
        unique case (i_step)
            STEP_FWD: begin
                if (day_inc > {1'b0, len_cur}) begin
                    o_date.day = DAY_W'(1);
                    if (i_date.month >= MONTH_DEC) begin
                        o_date.month = MONTH_JAN;
                        o_date.year  = (i_date.year >= YEAR_LAST) ? '0 : i_date.year + 1'b1;
                    end else begin
                        o_date.month = i_date.month + 1'b1;
                    end
                end else begin
                    o_date.day = day_inc[DAY_W-1:0];
                end
            end
            STEP_BACK: begin
                if (i_date.day <= DAY_W'(1)) begin
                    o_date.day   = len_prev;
                    o_date.month = month_prev;
                    o_date.year  = year_prev;
                end else begin
                    o_date.day = i_date.day - 1'b1;
                end
            end
            default: begin
                o_date = i_date;
            end
        endcase
    end

endmodule

// File: rtl/core/timezone_date_adjust.sv
`timescale 1ns / 1ps

// Time zone adjust for binary RTC readings.
// Slave stream (s_axis_*) takes one reading per word: seconds, minutes,
// hours, day, month and two-digit year (2000 + year). The master stream
// (m_axis_*) returns the same fields with the configured hour offset
// applied: hours wrap at 24 and every wrap carries or borrows one day,
// rolling over month ends (February 29 in leap years), December/January
// and year 99/0. Seconds and minutes pass through.
// hour_offset is a signed 6-bit register at APB address 0; write it only
// while no words are in flight. pready is tied high.
// Each word passes the input register, then the result register. Throughput:
// one word per cycle while the receiver does not stall; each word is a
// single pass through the hour wrap and two chained day steps.
// Reset (synchronous, active low) empties both stages and clears the
// offset to zero. When the receiver stalls, the result stays in the output
// register, the input register still takes one more word, and tready drops
// only when both are full.
module timezone_date_adjust (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [5:0] seconds, [11:6] minutes, [16:12] hours, [21:17] day,
    // [25:22] month, [32:26] year, [39:33] zero
    input  logic [tzda_pkg::TDATA_W-1:0]     s_axis_tdata,
    // master stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [5:0] seconds, [11:6] minutes, [16:12] hours, [21:17] day,
    // [25:22] month, [32:26] year, [39:33] zero
    output logic [tzda_pkg::TDATA_W-1:0]     m_axis_tdata,
    // config port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tzda_pkg::PADDR_W-1:0]     paddr,
    input  logic [tzda_pkg::PDATA_W-1:0]     pwdata,
    output logic [tzda_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);
    import tzda_pkg::*;

    logic signed [OFFS_W-1:0] hour_offset;

    // input stage
    logic                r_a_valid;
    logic [USED_W-1:0]   r_a_data;
    logic                a_adv;
    logic                s_accept;

    // result stage
    logic                r_b_valid;
    logic [SEC_W-1:0]    r_b_sec;
    logic [MIN_W-1:0]    r_b_min;
    logic [HOUR_W-1:0]   r_b_hours;
    t_date               r_b_date;

    logic [HOUR_W-1:0]   a_hours;
    t_date               a_date;
    t_date               mid_date;
    t_date               n_date;
    logic [HOUR_W-1:0]   n_hours;
    t_wrap               wrap;

    tzda_cfg_regs u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_hour_offset (hour_offset)
    );

    // stage A moves on when stage B is empty or being drained
    assign a_adv         = !r_b_valid || m_axis_tready;
    assign s_axis_tready = !r_a_valid || a_adv;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_a_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_a_data <= s_axis_tdata[USED_W-1:0];
        end
    end

    // unpack the held word
    assign a_hours    = r_a_data[HOUR_LSB +: HOUR_W];
    assign a_date.day   = r_a_data[DAY_LSB +: DAY_W];
    assign a_date.month = r_a_data[MONTH_LSB +: MONTH_W];
    assign a_date.year  = r_a_data[YEAR_LSB +: YEAR_W];

    tzda_hour_wrap u_wrap (
        .i_hours  (a_hours),
        .i_offset (hour_offset),
        .o_hours  (n_hours),
        .o_wrap   (wrap)
    );

    // two day steps at most; the second one sees the first one's date
    tzda_cal_step u_step1 (
        .i_date (a_date),
        .i_step (wrap.step1),
        .o_date (mid_date)
    );

    tzda_cal_step u_step2 (
        .i_date (mid_date),
        .i_step (wrap.step2),
        .o_date (n_date)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv && r_a_valid) begin
            r_b_sec   <= r_a_data[SEC_LSB +: SEC_W];
            r_b_min   <= r_a_data[MIN_LSB +: MIN_W];
            r_b_hours <= n_hours;
            r_b_date  <= n_date;
        end
    end

    assign m_axis_tvalid = r_b_valid;
    assign m_axis_tdata  = {{(TDATA_W-USED_W){1'b0}},
                            r_b_date.year, r_b_date.month, r_b_date.day,
                            r_b_hours, r_b_min, r_b_sec};

    // local hour is always in range after the wrap
    a_hours_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_b_hours < HOURS_PER_DAY))
        else $error("output hour out of range");

    // reset empties both stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_a_valid && !r_b_valid))
        else $error("pipeline not empty after reset");

    // a full, blocked input stage must not take another word
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !a_adv) |-> !s_axis_tready)
        else $error("input stage overrun");

    // a second day step always goes the same way as the first
    a_step_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && (wrap.step2 != STEP_NONE)) |-> (wrap.step1 == wrap.step2))
        else $error("inconsistent day steps");

endmodule
